>>> rtl/core/mme_pkg.sv
package mme_pkg;

   localparam int FIELD_W       = 32;
   localparam int MODE_W        = 2;
   localparam int INDEX_W       = 4;
   localparam int SIZE_W        = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int RESET_SIZE    = 16;
   localparam int STEP_W        = 4;

   // request modes
   localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ_C  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_A     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_B     = 2'd2;

   // microprogram step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd1;
   localparam logic [STEP_W-1:0] STEP_WRITE    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ERROR    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MAC      = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DRAIN0   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DRAIN1   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DRAIN2   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd8;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [INDEX_W-1:0]        row_index;
      logic [INDEX_W-1:0]        col_index;
      logic signed [FIELD_W-1:0] element_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] product_value;
      logic                      index_error;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      COND_NEXT   = 2'd0,
      COND_ALWAYS = 2'd1,
      COND_WAIT   = 2'd2,
      COND_MORE   = 2'd3
   } cond_type;

   typedef struct packed {
      logic              idle;
      logic              dispatch;
      logic              write;
      logic              error;
      logic              issue;
      logic              emit;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctl_word_type;

   // control store
   function automatic ctl_word_type mme_ucode(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      w = '0;
      w.cond = COND_NEXT;
      w.target = STEP_IDLE;
      unique case (step)
         STEP_IDLE: begin
            w.idle = 1'b1;
            w.cond = COND_WAIT;
            w.target = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            w.dispatch = 1'b1;
         end
         STEP_WRITE: begin
            w.write = 1'b1;
            w.cond = COND_ALWAYS;
         end
         STEP_ERROR: begin
            w.error = 1'b1;
            w.cond = COND_ALWAYS;
         end
         STEP_MAC: begin
            w.issue = 1'b1;
            w.cond = COND_MORE;
            w.target = STEP_MAC;
         end
         STEP_DRAIN0, STEP_DRAIN1, STEP_DRAIN2: begin
            w.cond = COND_NEXT;
         end
         STEP_EMIT: begin
            w.emit = 1'b1;
            w.cond = COND_ALWAYS;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/mme_ram.sv
module mme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/matrix_multiply_engine.sv
// Channel    Ports                               Direction  Transaction
// request    start, busy, req_payload            in         start && !busy
// response   rsp_valid, rsp_payload              out        rsp_valid, one cycle
// csr        csr_valid, csr_ready, csr_index,    in         csr_valid && csr_ready
//            csr_data
//
// A write or an index error passes from acceptance through dispatch and a write or error step back
// to idle; mode 3 returns from dispatch straight to idle. A read of C issues one multiply-accumulate
// per term through the shared MAC pipeline (store read, multiply, partial sum, accumulate), then
// passes through the drain steps to emit; with inner_size zero it goes from dispatch straight to emit.
// Reset is synchronous: sizes return to RESET_SIZE (16) clamped to MAX_DIM, store contents are kept.
// The response is a one-cycle strobe that the receiver cannot stall.
module matrix_multiply_engine #(
   parameter int MAX_DIM     = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  mme_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   output mme_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mme_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mme_pkg::SIZE_W-1:0]           csr_data
);

   import mme_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int K_W    = $clog2(MAX_DIM);
   localparam int CNT_W  = K_W + 1;
   localparam int HALF   = VALUE_WIDTH / 2;
   localparam int FRAC   = VALUE_WIDTH / 2;
   localparam int ACC_W  = 2 * VALUE_WIDTH + $clog2(MAX_DIM) + 1;
   localparam int PLO_W  = VALUE_WIDTH + HALF + 1;
   localparam int PHI_W  = 2 * VALUE_WIDTH - HALF;
   localparam int TOP_W  = ACC_W - FRAC - VALUE_WIDTH + 1;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] s;
      s = v;
      if (int'(v) > MAX_DIM) begin
         s = SIZE_W'(MAX_DIM);
      end
      return s;
   endfunction

   // sequencer
   logic [STEP_W-1:0]       pc_ff, pc_in;
   ctl_word_type            ctl;
   logic [STEP_W-1:0]       dispatch_target;

   // held transaction and sizes
   req_payload_type         req_ff, req_in;
   logic [SIZE_W-1:0]       rows_a_ff, rows_a_in;
   logic [SIZE_W-1:0]       inner_size_ff, inner_size_in;
   logic [SIZE_W-1:0]       cols_b_ff, cols_b_in;

   // MAC datapath
   logic [K_W-1:0]          k_ff, k_in;
   logic [CNT_W-1:0]        k_ext;
   logic                    more;
   logic                    rd_valid_ff, p_valid_ff, s_valid_ff;
   logic signed [PLO_W-1:0] p_lo_ff, p_lo_in;
   logic signed [PHI_W-1:0] p_hi_ff, p_hi_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [TOP_W-1:0]        sat_top;
   logic signed [VALUE_WIDTH-1:0] sat_value;

   // stores
   logic                    a_wr_en, b_wr_en;
   logic [ADDR_W-1:0]       wr_addr, a_rd_addr, b_rd_addr;
   logic [VALUE_WIDTH-1:0]  wr_data, a_rd_data, b_rd_data;
   logic signed [VALUE_WIDTH-1:0] a_operand;

   // response
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   logic                    a_ok, b_ok, c_ok;

   assign ctl       = mme_ucode(pc_ff);
   assign busy      = !ctl.idle;
   assign csr_ready = 1'b1;

   assign a_ok = (SIZE_W'(req_ff.row_index) < rows_a_ff) &&
                 (SIZE_W'(req_ff.col_index) < inner_size_ff);
   assign b_ok = (SIZE_W'(req_ff.row_index) < inner_size_ff) &&
                 (SIZE_W'(req_ff.col_index) < cols_b_ff);
   assign c_ok = (SIZE_W'(req_ff.row_index) < rows_a_ff) &&
                 (SIZE_W'(req_ff.col_index) < cols_b_ff);

   always_comb begin
      unique case (req_ff.mode)
         MODE_WRITE_A: dispatch_target = a_ok ? STEP_WRITE : STEP_ERROR;
         MODE_WRITE_B: dispatch_target = b_ok ? STEP_WRITE : STEP_ERROR;
         MODE_READ_C: begin
            if (!c_ok) begin
               dispatch_target = STEP_ERROR;
            end else if (inner_size_ff == '0) begin
               dispatch_target = STEP_EMIT;
            end else begin
               dispatch_target = STEP_MAC;
            end
         end
         default: dispatch_target = STEP_IDLE;
      endcase
   end

   assign k_ext = {1'b0, k_ff};
   assign more  = (k_ext + CNT_W'(1)) != CNT_W'(inner_size_ff);

   always_comb begin
      pc_in = pc_ff + STEP_W'(1);
      unique case (ctl.cond)
         COND_NEXT:   pc_in = pc_ff + STEP_W'(1);
         COND_ALWAYS: pc_in = ctl.target;
         COND_WAIT: begin
            if (!start) begin
               pc_in = ctl.target;
            end
         end
         COND_MORE: begin
            if (more) begin
               pc_in = ctl.target;
            end
         end
         default: pc_in = STEP_IDLE;
      endcase
      if (ctl.dispatch) begin
         pc_in = dispatch_target;
      end
   end

   always_comb begin
      req_in        = req_ff;
      rows_a_in     = rows_a_ff;
      inner_size_in = inner_size_ff;
      cols_b_in     = cols_b_ff;
      if (ctl.idle && start) begin
         req_in = req_payload;
      end
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROWS_A:     rows_a_in     = clamp_size(csr_data);
            CSR_INNER_SIZE: inner_size_in = clamp_size(csr_data);
            CSR_COLS_B:     cols_b_in     = clamp_size(csr_data);
            default:        ;
         endcase
      end
   end

   // store ports
   assign wr_addr   = ADDR_W'(req_ff.row_index) * ADDR_W'(MAX_DIM) +
                      ADDR_W'(req_ff.col_index);
   assign wr_data   = VALUE_WIDTH'(req_ff.element_value);
   assign a_wr_en   = ctl.write && (req_ff.mode == MODE_WRITE_A);
   assign b_wr_en   = ctl.write && (req_ff.mode == MODE_WRITE_B);
   assign a_rd_addr = ADDR_W'(req_ff.row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(k_ff);
   assign b_rd_addr = ADDR_W'(k_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(req_ff.col_index);

   mme_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mme_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // multiply as two half-width partial products of B
   assign a_operand = $signed(a_rd_data);

   always_comb begin
      p_lo_in = a_operand * $signed({1'b0, b_rd_data[HALF-1:0]});
      p_hi_in = a_operand * $signed(b_rd_data[VALUE_WIDTH-1:HALF]);
      prod_in = (ACC_W'(p_hi_ff) <<< HALF) + ACC_W'(p_lo_ff);
   end

   always_comb begin
      k_in   = k_ff;
      acc_in = acc_ff;
      if (ctl.dispatch) begin
         k_in   = '0;
         acc_in = '0;
      end else begin
         if (ctl.issue) begin
            k_in = k_ff + K_W'(1);
         end
         if (s_valid_ff) begin
            acc_in = acc_ff + prod_ff;
         end
      end
   end

   // drop fraction bits, saturate on overflow of the upper bits
   assign sat_top = acc_ff[ACC_W-1:FRAC+VALUE_WIDTH-1];

   always_comb begin
      if ((&sat_top) || !(|sat_top)) begin
         sat_value = acc_ff[FRAC+VALUE_WIDTH-1:FRAC];
      end else if (acc_ff[ACC_W-1]) begin
         sat_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
   end

   always_comb begin
      rsp_valid_in   = ctl.emit || ctl.error;
      rsp_payload_in = rsp_payload_ff;
      if (ctl.error) begin
         rsp_payload_in.product_value = '0;
         rsp_payload_in.index_error   = 1'b1;
      end else if (ctl.emit) begin
         rsp_payload_in.product_value = FIELD_W'(sat_value);
         rsp_payload_in.index_error   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_IDLE;
         rows_a_ff     <= clamp_size(SIZE_W'(RESET_SIZE));
         inner_size_ff <= clamp_size(SIZE_W'(RESET_SIZE));
         cols_b_ff     <= clamp_size(SIZE_W'(RESET_SIZE));
         rd_valid_ff   <= 1'b0;
         p_valid_ff    <= 1'b0;
         s_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         rows_a_ff     <= rows_a_in;
         inner_size_ff <= inner_size_in;
         cols_b_ff     <= cols_b_in;
         rd_valid_ff   <= ctl.issue;
         p_valid_ff    <= rd_valid_ff;
         s_valid_ff    <= p_valid_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      k_ff           <= k_in;
      acc_ff         <= acc_in;
      p_lo_ff        <= p_lo_in;
      p_hi_ff        <= p_hi_in;
      prod_ff        <= prod_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (pc_ff == STEP_DISPATCH))
      else $error("accepted transaction not dispatched");

   a_emit_result: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_EMIT) |=> (rsp_valid && !rsp_payload.index_error))
      else $error("dot product result missing after emit");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.issue |-> (k_ext < CNT_W'(inner_size_ff)))
      else $error("inner index beyond dot product length");

   a_acc_in_read: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> (pc_ff == STEP_MAC || pc_ff == STEP_DRAIN0 ||
                      pc_ff == STEP_DRAIN1 || pc_ff == STEP_DRAIN2))
      else $error("accumulate outside of a read");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mme_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int DIM = 16;
   localparam int FRAC_BITS = FIELD_W / 2;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 80;
   localparam int DRAIN_CYCLES = 24;
   localparam int REPORT_LIMIT = 10;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
   localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

   class matmul_scoreboard;
      logic signed [FIELD_W-1:0] a_elems [DIM*DIM];
      logic signed [FIELD_W-1:0] b_elems [DIM*DIM];
      int unsigned rows_a = DIM;
      int unsigned inner_size = DIM;
      int unsigned cols_b = DIM;
      rsp_payload_type expected_products [$];
      int mismatch_count = 0;

      function void set_size(logic [CSR_INDEX_W-1:0] idx, logic [SIZE_W-1:0] value);
         int unsigned size;
         size = (value > DIM) ? DIM : value;
         case (idx)
            CSR_ROWS_A: rows_a = size;
            CSR_INNER_SIZE: inner_size = size;
            CSR_COLS_B: cols_b = size;
            default: ;
         endcase
      endfunction

      // Update the stores and queue the product this transaction must produce.
      function void note_request(req_payload_type r);
         rsp_payload_type prediction;
         logic signed [127:0] acc;
         logic signed [127:0] scaled;
         logic [7:0] addr;
         int k;
         prediction = '0;
         acc = '0;
         addr = {r.row_index, r.col_index};
         case (r.mode)
            MODE_WRITE_A: begin
               if (r.row_index < rows_a && r.col_index < inner_size) begin
                  a_elems[addr] = r.element_value;
                  return;
               end
               prediction.index_error = 1'b1;
            end
            MODE_WRITE_B: begin
               if (r.row_index < inner_size && r.col_index < cols_b) begin
                  b_elems[addr] = r.element_value;
                  return;
               end
               prediction.index_error = 1'b1;
            end
            MODE_READ_C: begin
               if (r.row_index < rows_a && r.col_index < cols_b) begin
                  for (k = 0; k < inner_size; k++)
                     acc += longint'(a_elems[{r.row_index, k[3:0]}])
                          * longint'(b_elems[{k[3:0], r.col_index}]);
                  // floor to Q16.16, then clamp to the signed 32-bit range
                  scaled = acc >>> FRAC_BITS;
                  if (scaled > Q_MAX)
                     prediction.product_value = Q_MAX[FIELD_W-1:0];
                  else if (scaled < Q_MIN)
                     prediction.product_value = Q_MIN[FIELD_W-1:0];
                  else
                     prediction.product_value = scaled[FIELD_W-1:0];
               end else begin
                  prediction.index_error = 1'b1;
               end
            end
            default: return;
         endcase
         expected_products.push_back(prediction);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_products.size() == 0) begin
            flag($sformatf("unexpected result product_value %h index_error %b",
                           got.product_value, got.index_error));
            return;
         end
         want = expected_products.pop_front();
         if (got.product_value !== want.product_value)
            flag($sformatf("product_value expected %h actual %h",
                           want.product_value, got.product_value));
         if (got.index_error !== want.index_error)
            flag($sformatf("index_error expected %b actual %b",
                           want.index_error, got.index_error));
      endfunction

      function void flag(string what);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0] csr_data = '0;
   int quiet_cycles = 0;
   bit steady_sender = 1'b0;
   matmul_scoreboard board;

   matrix_multiply_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_payload);
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [FIELD_W-1:0] pick_value(bit wide);
      int unsigned k;
      k = wide ? $urandom_range(0, 9) : 0;
      if (k < 7)
         return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
      if (k == 7)
         return $urandom;
      if (k == 8)
         return 32'h7FFF_FFFF;
      return 32'h8000_0000;
   endfunction

   task automatic send(logic [MODE_W-1:0] mode, int row, int col,
                       logic [FIELD_W-1:0] value);
      req_payload_type item;
      int gap;
      item.mode = mode;
      item.row_index = INDEX_W'(row);
      item.col_index = INDEX_W'(col);
      item.element_value = value;
      gap = steady_sender ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(item);
   endtask

   task automatic send_random();
      int unsigned kind;
      int row_lim;
      int col_lim;
      int row;
      int col;
      logic [MODE_W-1:0] mode;
      kind = $urandom_range(0, 99);
      row = $urandom_range(0, DIM - 1);
      col = $urandom_range(0, DIM - 1);
      if (kind < 5)
         mode = MODE_UNUSED;
      else if (kind < 50)
         mode = $urandom_range(0, 1) ? MODE_WRITE_B : MODE_WRITE_A;
      else
         mode = MODE_READ_C;
      // mostly aim inside the configured sizes; leave the rest anywhere
      if (mode != MODE_UNUSED && $urandom_range(0, 9) != 0) begin
         case (mode)
            MODE_WRITE_A: begin
               row_lim = board.rows_a;
               col_lim = board.inner_size;
            end
            MODE_WRITE_B: begin
               row_lim = board.inner_size;
               col_lim = board.cols_b;
            end
            default: begin
               row_lim = board.rows_a;
               col_lim = board.cols_b;
            end
         endcase
         if (row_lim > 0)
            row = $urandom_range(0, row_lim - 1);
         if (col_lim > 0)
            col = $urandom_range(0, col_lim - 1);
      end
      send(mode, row, col, pick_value(1'b1));
   endtask

   task automatic program_sizes(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] inner,
                                logic [SIZE_W-1:0] cols);
      logic [SIZE_W-1:0] values [3];
      logic [CSR_INDEX_W-1:0] regs [3];
      int i;
      values = '{rows, inner, cols};
      regs = '{CSR_ROWS_A, CSR_INNER_SIZE, CSR_COLS_B};
      csr_valid <= 1'b1;
      for (i = 0; i < 3; i++) begin
         csr_index <= regs[i];
         csr_data <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         board.set_size(regs[i], values[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Drop start and let every outstanding transaction finish.
   task automatic settle();
      start <= 1'b0;
      while (board.expected_products.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [SIZE_W-1:0] fixed_sizes [8][3];
      logic [SIZE_W-1:0] sel_rows;
      logic [SIZE_W-1:0] sel_inner;
      logic [SIZE_W-1:0] sel_cols;
      logic [FIELD_W-1:0] edge_value;
      int i;
      int j;
      int phase;
      fixed_sizes = '{'{16, 16, 16}, '{1, 1, 1}, '{4, 16, 3}, '{16, 1, 16},
                      '{31, 24, 17}, '{0, 8, 5}, '{7, 0, 9}, '{5, 9, 0}};
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      program_sizes(5'd16, 5'd16, 5'd16);

      // Fill both stores; rows of A and columns of B 0..3 carry edge values.
      for (i = 0; i < DIM; i++) begin
         case (i)
            0: edge_value = 32'h7FFF_FFFF;
            1: edge_value = 32'h8000_0000;
            2: edge_value = 32'h0000_0001;
            3: edge_value = 32'h0001_0000;
            default: edge_value = '0;
         endcase
         for (j = 0; j < DIM; j++) begin
            send(MODE_WRITE_A, i, j, (i < 4) ? edge_value : pick_value(1'b0));
            if (i == 2)
               send(MODE_WRITE_B, j, i, 32'hFFFF_FFFF);
            else
               send(MODE_WRITE_B, j, i, (i < 4) ? edge_value : pick_value(1'b0));
         end
      end

      // saturation both ways, floor of a tiny negative sum, exact unit sum
      send(MODE_READ_C, 0, 0, '0);
      send(MODE_READ_C, 1, 0, '0);
      send(MODE_READ_C, 0, 1, '0);
      send(MODE_READ_C, 1, 1, 32'hFFFF_FFFF);
      send(MODE_READ_C, 2, 2, '0);
      send(MODE_READ_C, 3, 3, '0);
      send(MODE_READ_C, 15, 15, '0);
      send(MODE_UNUSED, 15, 15, 32'hFFFF_FFFF);

      settle();
      program_sizes(5'd1, 5'd1, 5'd1);
      send(MODE_WRITE_A, 0, 0, 32'h0002_0000);
      send(MODE_WRITE_A, 1, 0, 32'h1234_5678);
      send(MODE_WRITE_A, 0, 1, 32'h1234_5678);
      send(MODE_WRITE_B, 0, 0, 32'hFFFF_0000);
      send(MODE_WRITE_B, 1, 0, 32'h1234_5678);
      send(MODE_WRITE_B, 0, 1, 32'h1234_5678);
      send(MODE_READ_C, 0, 0, '0);
      send(MODE_READ_C, 0, 1, '0);
      send(MODE_READ_C, 1, 0, '0);

      // oversized values clamp; a zero inner size gives an empty sum
      settle();
      program_sizes(5'd31, 5'd0, 5'd17);
      send(MODE_READ_C, 15, 15, '0);
      send(MODE_WRITE_A, 0, 0, 32'h0001_0000);
      send(MODE_WRITE_B, 0, 0, 32'h0001_0000);

      settle();
      program_sizes(5'd0, 5'd16, 5'd0);
      send(MODE_READ_C, 0, 0, '0);
      send(MODE_WRITE_A, 0, 0, 32'h0001_0000);
      send(MODE_WRITE_B, 0, 0, 32'h0001_0000);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         if (phase < 8) begin
            sel_rows = fixed_sizes[phase][0];
            sel_inner = fixed_sizes[phase][1];
            sel_cols = fixed_sizes[phase][2];
         end else begin
            sel_rows = $urandom_range(0, 31);
            sel_inner = $urandom_range(0, 31);
            sel_cols = $urandom_range(0, 31);
         end
         program_sizes(sel_rows, sel_inner, sel_cols);
         steady_sender = ($urandom_range(0, 2) == 0);
         repeat (PHASE_ITEMS) send_random();
      end
      steady_sender = 1'b0;

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.expected_products.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
